[rtl/sts_pkg.sv]
// Shared types and constants of the s-expression token scanner.
`default_nettype none

package sts_pkg;

	// Token kinds as they appear on the result channel.
	typedef enum logic [2:0] {
		KIND_WORD   = 3'd0,
		KIND_NUMBER = 3'd1,
		KIND_LEFT   = 3'd2,
		KIND_RIGHT  = 3'd3,
		KIND_END    = 3'd4,
		KIND_ERROR  = 3'd5
	} kind_t;

	// Scanner state: between tokens, inside a word, inside a number, or done after a NUL.
	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_NUMBER  = 2'd2,
		MODE_DONE    = 2'd3
	} mode_t;

	localparam int unsigned START_W = 16;
	localparam int unsigned END_W   = 17;
	localparam int unsigned VALUE_W = 64;

	// One result transaction.
	typedef struct packed {
		kind_t                     kind;
		logic [START_W-1:0]        start_pos;
		logic signed [END_W-1:0]   end_pos;
		logic [VALUE_W-1:0]        number_value;
		logic                      last;
	} result_t;

	// Results produced by one scanned character.
	typedef struct packed {
		logic    [1:0] count;
		result_t       first;
		result_t       second;
	} scan_out_t;

	// Result queue: room for two pushes in a cycle plus two waiting entries.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

endpackage

`default_nettype wire

[rtl/sexp_token_scanner.sv]
// Top level of the streaming s-expression token scanner.
//
// Input channel: one transaction per character (ch) or end-of-text marker
// (end_of_text), on in_valid / in_stall. Output channel: one transaction per
// token (kind, start_pos, end_pos, number_value, last) on out_valid /
// out_stall; last marks the final token caused by one input transaction.
// An accepted character is held in the input register while the scanner
// classifies it and updates its state; the scanner steps only while the
// queue has room, and then writes the character's tokens into the
// four-entry result queue, whose head drives the output channel.
// Throughput is one character per cycle as long as characters give at most
// one token each and the receiver does not stall; a character that closes a
// word or number and is a token itself gives two, sent out one by one.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than two entries are free; nothing is lost.
// Reset clears the scanner to between-tokens at position zero and empties
// the queue. Positions wrap modulo MAX_TEXT_LEN.
`default_nettype none

module sexp_token_scanner #(
	parameter int unsigned MAX_TEXT_LEN = 65536
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_stall,
	input  wire  [7:0]    ch,
	input  wire           end_of_text,
	output logic          out_valid,
	input  wire           out_stall,
	output logic [2:0]    kind,
	output logic [15:0]   start_pos,
	output logic signed [16:0] end_pos,
	output logic [63:0]   number_value,
	output logic          last
);
	import sts_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        eot_s1;
	logic        room;
	logic        advance;
	scan_out_t   scan_out;
	result_t     head;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1  <= ch;
			eot_s1 <= end_of_text;
		end
	end

	sts_scan #(
		.MAX_TEXT_LEN (MAX_TEXT_LEN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.ch          (ch_s1),
		.end_of_text (eot_s1),
		.scan_out    (scan_out)
	);

	sts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (scan_out),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind         = head.kind;
	assign start_pos    = head.start_pos;
	assign end_pos      = head.end_pos;
	assign number_value = head.number_value;
	assign last         = head.last;

endmodule

`default_nettype wire

[rtl/sts_scan.sv]
// Character classifier, token state and token builder of the scanner.
`default_nettype none

module sts_scan #(
	parameter int unsigned MAX_TEXT_LEN = 65536
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  wire  [7:0]             ch,
	input  wire                    end_of_text,
	output sts_pkg::scan_out_t     scan_out
);
	import sts_pkg::*;

	localparam int unsigned PW = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_TEXT_LEN - 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d ||
			c == 8'h0c || c == 8'h0b;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == 8'h2d || c == 8'h2e ||
			c == 8'h5f || c == 8'h3a || c == 8'h2a || c == 8'h2b || c == 8'h3d;
	endfunction

	mode_t                mode_q, mode_d;
	logic [PW-1:0]        pos_q, pos_d;
	logic [PW-1:0]        start_q, start_d;
	logic [VALUE_W-1:0]   acc_q, acc_d;

	logic [PW-1:0]        pos_next, pos_prev;
	logic [PW+15:0]       pos_wide, prev_wide, start_wide;
	logic [START_W-1:0]   pos16, prev16, start16;
	logic [VALUE_W-1:0]   acc_times_ten;
	logic [3:0]           digit;

	result_t              flush_res, end_res, char_res;
	logic                 flush_ok, tok_ok;
	result_t              tok_res;

	assign pos_next = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign pos_prev = (pos_q == '0) ? POS_LAST : pos_q - 1'b1;

	// Positions leave the block masked to the 16-bit field.
	assign pos_wide   = {16'b0, pos_q};
	assign prev_wide  = {16'b0, pos_prev};
	assign start_wide = {16'b0, start_q};
	assign pos16      = pos_wide[15:0];
	assign prev16     = prev_wide[15:0];
	assign start16    = start_wide[15:0];

	assign digit         = ch[3:0];
	assign acc_times_ten = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
		+ {{(VALUE_W-4){1'b0}}, digit};

	always_comb begin
		flush_res.kind         = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_WORD;
		flush_res.start_pos    = start16;
		flush_res.end_pos      = {1'b0, prev16};
		flush_res.number_value = (mode_q == MODE_NUMBER) ? acc_q : '0;
		flush_res.last         = 1'b0;

		// End token: its last index is one before its start, or -1 at zero.
		end_res.kind         = KIND_END;
		end_res.start_pos    = pos16;
		end_res.end_pos      = (pos16 == '0) ? '1 : {1'b0, pos16 - 16'd1};
		end_res.number_value = '0;
		end_res.last         = 1'b0;

		char_res.kind         = KIND_ERROR;
		char_res.start_pos    = pos16;
		char_res.end_pos      = {1'b0, pos16};
		char_res.number_value = '0;
		char_res.last         = 1'b0;
		if (ch == CH_LPAREN) begin
			char_res.kind = KIND_LEFT;
		end else if (ch == CH_RPAREN) begin
			char_res.kind = KIND_RIGHT;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		start_d  = start_q;
		acc_d    = acc_q;
		flush_ok = 1'b0;
		tok_ok   = 1'b0;
		tok_res  = end_res;

		if (end_of_text) begin
			if (mode_q != MODE_DONE) begin
				flush_ok = (mode_q == MODE_WORD) || (mode_q == MODE_NUMBER);
				tok_ok   = 1'b1;
			end
			mode_d  = MODE_BETWEEN;
			pos_d   = '0;
			start_d = '0;
			acc_d   = '0;
		end else if (mode_q == MODE_DONE) begin
			mode_d = MODE_DONE;
		end else if (mode_q == MODE_WORD && is_word(ch)) begin
			pos_d = pos_next;
		end else if (mode_q == MODE_NUMBER && is_digit(ch)) begin
			acc_d = acc_times_ten;
			pos_d = pos_next;
		end else begin
			flush_ok = (mode_q == MODE_WORD) || (mode_q == MODE_NUMBER);
			mode_d   = MODE_BETWEEN;
			if (ch == CH_NUL) begin
				tok_ok = 1'b1;
				mode_d = MODE_DONE;
			end else begin
				pos_d = pos_next;
				if (ch == CH_LPAREN || ch == CH_RPAREN) begin
					tok_ok  = 1'b1;
					tok_res = char_res;
				end else if (is_letter(ch)) begin
					mode_d  = MODE_WORD;
					start_d = pos_q;
					acc_d   = '0;
				end else if (is_digit(ch)) begin
					mode_d  = MODE_NUMBER;
					start_d = pos_q;
					acc_d   = {{(VALUE_W-4){1'b0}}, digit};
				end else if (!is_space(ch)) begin
					tok_ok  = 1'b1;
					tok_res = char_res;
				end
			end
		end
	end

	always_comb begin
		scan_out.count  = {1'b0, flush_ok} + {1'b0, tok_ok};
		scan_out.first  = flush_ok ? flush_res : tok_res;
		scan_out.second = tok_res;
		scan_out.first.last  = !(flush_ok && tok_ok);
		scan_out.second.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			pos_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			acc_q   <= acc_d;
		end
	end

endmodule

`default_nettype wire

[rtl/sts_queue.sv]
// Result queue taking up to two results per cycle and giving one when the receiver does not stall.
`default_nettype none

module sts_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  sts_pkg::scan_out_t     push_data,
	output logic                   room,
	output logic                   out_valid,
	input  wire                    out_stall,
	output sts_pkg::result_t       head
);
	import sts_pkg::*;

	result_t             mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   count_q;
	logic [1:0]          n_push;
	logic                pop;
	logic [QPTR_W-1:0]   wr_next;

	assign n_push    = push ? push_data.count : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	// Two free entries are kept so a character giving two tokens never overflows.
	assign room      = (count_q <= QCNT_W'(QDEPTH - 2));
	assign head      = mem[rd_q];
	assign wr_next   = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_q] <= push_data.first;
		end
		if (n_push == 2'd2) begin
			mem[wr_next] <= push_data.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(n_push);
			rd_q    <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire
